[rtl/core/flra_pkg.sv]
// ----------------------------------------------------------------------------
// flra_pkg: shared types and constants of the framed link receiver
// Codes, the per-type content length rule table, and the state and result
// structs passed between the step logic, the result buffer and the top level.
// ----------------------------------------------------------------------------
package flra_pkg;

	// number of frame types the receiver knows; types at or above are rejected
	localparam int unsigned TYPE_COUNT = 15;
	// first type number beyond the rule table; such types take any length
	localparam int unsigned RULE_TYPES = 15;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 9;

	localparam logic [7:0] ACK_BYTE   = 8'hAA;
	localparam logic [7:0] NACK_BYTE  = 8'h55;
	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] TRAIL_BYTE = 8'hF0;

	localparam logic [7:0] TIMEOUT_RESET = 8'd90;
	localparam logic [8:0] PING_RESET    = 9'd300;

	// content length rules
	localparam logic [7:0] LEN_ANY = 8'd255;
	localparam logic [7:0] LEN_STR = 8'd254;

	// type number that marks the peer as opened
	localparam logic [7:0] TYPE_PEER_OPEN = 8'd13;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PING    = 8'd1;

	typedef enum logic [1:0] {
		IN_BYTE = 2'd0,
		IN_TICK = 2'd1,
		IN_SENT = 2'd2,
		IN_NONE = 2'd3
	} in_kind_t;

	typedef enum logic [2:0] {
		RES_TX       = 3'd0,
		RES_BODY     = 3'd1,
		RES_ACCEPTED = 3'd2,
		RES_REJECTED = 3'd3,
		RES_ACK_SEEN = 3'd4,
		RES_RESEND   = 3'd5,
		RES_TIMEOUT  = 3'd6,
		RES_PING     = 3'd7
	} res_kind_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_BODY  = 4'b0100,
		PH_TRAIL = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t     rx_phase;
		logic [7:0] bytes_left;
		logic [7:0] body_index;
		logic [7:0] frame_type;
		logic       zero_before_end;
		logic [7:0] last_body_byte;
		logic [7:0] rx_age;
		logic       waiting_for_ack;
		logic [7:0] ack_age;
		logic [8:0] ping_count;
	} link_state_t;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [8:0] ping_period;
	} link_cfg_t;

	typedef struct packed {
		res_kind_t  kind;
		logic [7:0] data;
	} result_t;

	typedef struct packed {
		logic [2:0]              count;
		result_t [MAX_RESULTS-1:0] res;
	} result_list_t;

	// content length rule for the known types
	function automatic logic [7:0] type_rule(input logic [3:0] t);
		logic [7:0] r;
		begin
			case (t)
				4'd2, 4'd6, 4'd11: r = 8'd4;
				4'd3, 4'd9:        r = LEN_STR;
				4'd5:              r = 8'd6;
				4'd10:             r = 8'd1;
				default:           r = 8'd0;
			endcase
			return r;
		end
	endfunction

endpackage

[rtl/core/flra_step.sv]
// ----------------------------------------------------------------------------
// flra_step: per-item link logic
// Given the link state and one input beat, works out the next state and the
// ordered list of up to four results.
// ----------------------------------------------------------------------------
module flra_step #(
	parameter int unsigned TYPE_COUNT = flra_pkg::TYPE_COUNT
) (
	input  flra_pkg::link_state_t  st,
	input  flra_pkg::link_cfg_t    cfg,
	input  logic [1:0]             kind,
	input  logic [7:0]             rx_byte,
	output flra_pkg::link_state_t  st_next,
	output flra_pkg::result_list_t results
);

	function automatic flra_pkg::result_list_t push(
		input flra_pkg::result_list_t l,
		input flra_pkg::res_kind_t    k,
		input logic [7:0]             d
	);
		flra_pkg::result_list_t o;
		begin
			o = l;
			o.res[l.count[1:0]].kind = k;
			o.res[l.count[1:0]].data = d;
			o.count = l.count + 3'd1;
			return o;
		end
	endfunction

	logic       verdict_ok;
	logic [7:0] clen;
	logic [7:0] rule;
	logic [8:0] ping_inc;

	// verdict on the frame held in the state
	always_comb begin
		clen = st.body_index - 8'd1;
		rule = flra_pkg::type_rule(st.frame_type[3:0]);
		if (st.body_index == 8'd0) begin
			verdict_ok = 1'b0;
		end else if ({1'b0, st.frame_type} >= 9'(TYPE_COUNT)) begin
			verdict_ok = 1'b0;
		end else if ({1'b0, st.frame_type} >= 9'(flra_pkg::RULE_TYPES)) begin
			verdict_ok = 1'b1;
		end else if (rule == flra_pkg::LEN_STR) begin
			verdict_ok = (clen >= 8'd1) && (st.last_body_byte == 8'd0) &&
				!st.zero_before_end;
		end else if (rule == flra_pkg::LEN_ANY) begin
			verdict_ok = 1'b1;
		end else begin
			verdict_ok = (clen == rule);
		end
	end

	assign ping_inc = st.ping_count + 9'd1;

	always_comb begin
		st_next = st;
		results = '0;
		case (flra_pkg::in_kind_t'(kind))
			flra_pkg::IN_BYTE: begin
				case (st.rx_phase)
					flra_pkg::PH_IDLE: begin
						if (rx_byte == flra_pkg::ACK_BYTE) begin
							if (st.waiting_for_ack) begin
								st_next.waiting_for_ack = 1'b0;
								results = push(results, flra_pkg::RES_ACK_SEEN, 8'd0);
							end
						end else if (rx_byte == flra_pkg::NACK_BYTE) begin
							if (st.waiting_for_ack) begin
								results = push(results, flra_pkg::RES_RESEND, 8'd0);
							end
						end else if (rx_byte == flra_pkg::START_BYTE) begin
							st_next.rx_phase = flra_pkg::PH_START;
							st_next.rx_age   = 8'd0;
						end
					end
					flra_pkg::PH_START: begin
						if (rx_byte == 8'd0) begin
							results = push(results, flra_pkg::RES_REJECTED, 8'd0);
							results = push(results, flra_pkg::RES_TX, flra_pkg::NACK_BYTE);
							st_next.rx_phase = flra_pkg::PH_IDLE;
						end else begin
							st_next.rx_phase        = flra_pkg::PH_BODY;
							st_next.rx_age          = 8'd0;
							st_next.bytes_left      = rx_byte;
							st_next.body_index      = 8'd0;
							st_next.zero_before_end = 1'b0;
							st_next.last_body_byte  = 8'd0;
						end
					end
					flra_pkg::PH_BODY: begin
						results = push(results, flra_pkg::RES_BODY, rx_byte);
						if (st.body_index == 8'd0) begin
							st_next.frame_type = rx_byte;
						end else begin
							// a zero inside the content, not at its end
							if (st.body_index >= 8'd2 && st.last_body_byte == 8'd0)
								st_next.zero_before_end = 1'b1;
							st_next.last_body_byte = rx_byte;
						end
						if (st.body_index != 8'd255)
							st_next.body_index = st.body_index + 8'd1;
						if (st.bytes_left <= 8'd1) begin
							st_next.bytes_left = 8'd0;
							st_next.rx_phase   = flra_pkg::PH_TRAIL;
						end else begin
							st_next.bytes_left = st.bytes_left - 8'd1;
						end
					end
					default: begin
						st_next.rx_phase = flra_pkg::PH_IDLE;
						if (rx_byte == flra_pkg::TRAIL_BYTE && verdict_ok) begin
							results = push(results, flra_pkg::RES_ACCEPTED, 8'd0);
							results = push(results, flra_pkg::RES_TX, flra_pkg::ACK_BYTE);
							if (st.frame_type == flra_pkg::TYPE_PEER_OPEN) begin
								st_next.waiting_for_ack = 1'b0;
								st_next.ack_age         = 8'd0;
							end
						end else begin
							results = push(results, flra_pkg::RES_REJECTED, 8'd0);
							results = push(results, flra_pkg::RES_TX, flra_pkg::NACK_BYTE);
						end
					end
				endcase
			end
			flra_pkg::IN_TICK: begin
				st_next.ping_count = ping_inc;
				if (ping_inc >= cfg.ping_period) begin
					results = push(results, flra_pkg::RES_PING, 8'd0);
					st_next.ping_count = 9'd0;
				end
				if (st.waiting_for_ack) begin
					if (st.ack_age >= cfg.timeout_ticks) begin
						st_next.waiting_for_ack = 1'b0;
						results = push(results, flra_pkg::RES_TIMEOUT, 8'd0);
					end else begin
						st_next.ack_age = st.ack_age + 8'd1;
					end
				end
				if (st.rx_phase != flra_pkg::PH_IDLE) begin
					if (st.rx_age >= cfg.timeout_ticks) begin
						results = push(results, flra_pkg::RES_REJECTED, 8'd0);
						results = push(results, flra_pkg::RES_TX, flra_pkg::NACK_BYTE);
						st_next.rx_phase = flra_pkg::PH_IDLE;
					end else begin
						st_next.rx_age = st.rx_age + 8'd1;
					end
				end
			end
			flra_pkg::IN_SENT: begin
				st_next.waiting_for_ack = 1'b1;
				st_next.ack_age         = 8'd0;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/flra_obuf.sv]
// ----------------------------------------------------------------------------
// flra_obuf: result buffer
// Holds the results of one item and hands them out one beat per cycle
// while out_stall is low; entry zero is the output register.
// ----------------------------------------------------------------------------
module flra_obuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  flra_pkg::result_list_t results,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             out_kind,
	output logic [7:0]             out_byte,
	output logic                   last
);

	localparam int unsigned N = flra_pkg::MAX_RESULTS;

	typedef struct packed {
		flra_pkg::result_t res;
		logic              last;
	} entry_t;

	entry_t [N-1:0] ent_q;
	logic [2:0]     cnt_q;
	logic           pop;

	assign pop      = (cnt_q != 3'd0) && !out_stall;
	// a new item may enter once the last pending result leaves
	assign can_load = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= results.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < N; i++) begin
				ent_q[i].res  <= results.res[i];
				ent_q[i].last <= (results.count == 3'(i + 1));
			end
		end else if (pop) begin
			for (int i = 0; i < N - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign out_kind  = ent_q[0].res.kind;
	assign out_byte  = ent_q[0].res.data;
	assign last      = ent_q[0].last;

endmodule

[rtl/core/framed_link_receiver_ack_core.sv]
// ----------------------------------------------------------------------------
// framed_link_receiver_ack_core: framed serial link receiver with ACK/NACK
// Parses received frames, passes body bytes on, answers ACK or NACK, and
// tracks acknowledgement waits, partial-frame timeouts and ping requests.
// ----------------------------------------------------------------------------
// An input beat (received byte, timer tick or frame-sent notice) is taken at
// a clock edge: the link state is updated at that edge and the zero to four
// results it causes are loaded into a four-entry result buffer. Results leave
// one beat per cycle while out_stall is low, type byte first for body data;
// the last result of an item carries last. The next input beat is taken in
// the same cycle that the final pending result leaves. Configuration writes
// are always ready and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module framed_link_receiver_ack_core #(
	parameter int unsigned TYPE_COUNT = flra_pkg::TYPE_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [flra_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [flra_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic [7:0]                          rx_byte,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          out_kind,
	output logic [7:0]                          out_byte,
	output logic                                last
);

	flra_pkg::link_state_t  state_q;
	flra_pkg::link_state_t  state_next;
	flra_pkg::link_cfg_t    cfg_q;
	flra_pkg::result_list_t results;
	logic                   can_load;
	logic                   in_take;

	// registers: timeout and ping period; other indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= flra_pkg::TIMEOUT_RESET;
			cfg_q.ping_period   <= flra_pkg::PING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == flra_pkg::REG_TIMEOUT)
				cfg_q.timeout_ticks <= cfg_data[7:0];
			else if (cfg_index == flra_pkg::REG_PING)
				cfg_q.ping_period <= cfg_data;
		end
	end

	// input beat handshake follows the result buffer drain
	assign in_stall = !can_load;
	assign in_take  = in_valid && can_load;

	flra_step #(
		.TYPE_COUNT (TYPE_COUNT)
	) u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.kind    (kind),
		.rx_byte (rx_byte),
		.st_next (state_next),
		.results (results)
	);

	// link state: phase, frame bookkeeping, ack wait and ping counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rx_phase        <= flra_pkg::PH_IDLE;
			state_q.bytes_left      <= 8'd0;
			state_q.body_index      <= 8'd0;
			state_q.frame_type      <= 8'd0;
			state_q.zero_before_end <= 1'b0;
			state_q.last_body_byte  <= 8'd0;
			state_q.rx_age          <= 8'd0;
			state_q.waiting_for_ack <= 1'b0;
			state_q.ack_age         <= 8'd0;
			state_q.ping_count      <= 9'd0;
		end else if (in_take) begin
			state_q <= state_next;
		end
	end

	flra_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_take),
		.results   (results),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
